// ===== sv/gssf_pkg.sv =====
// Package of types, constants and kernel weights for the smoothed slope filter.
package gssf_pkg;

    localparam int KERNEL_RADIUS = 4;
    localparam int TAPS = 2 * KERNEL_RADIUS + 1;
    localparam int LAG = KERNEL_RADIUS + 1;

    localparam logic [23:0] SLOPE_SCALE = 24'd10000000;
    localparam logic [15:0] MIN_STEP_RESET = 16'd1000;
    localparam logic [23:0] CLAMP_LOW_RESET = 24'hFB0000;
    localparam logic [22:0] CLAMP_HIGH_RESET = 23'd1245184;

    localparam logic [1:0] CFG_MIN_STEP = 2'd0;
    localparam logic [1:0] CFG_CLAMP_LOW = 2'd1;
    localparam logic [1:0] CFG_CLAMP_HIGH = 2'd2;

    typedef struct packed {
        logic [31:0] sample_time_us;
        logic signed [23:0] sample_value;
        logic end_of_series;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_time_us;
        logic signed [23:0] smoothed_slope;
        logic last_result;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SLOPE,
        S_MUL,
        S_DIVSET,
        S_DIV,
        S_SLOPE_END,
        S_EMIT_START,
        S_TAP_LOAD,
        S_EMIT
    } t_state;

    function automatic logic [13:0] gauss_weight(input logic [3:0] k);
        logic [13:0] w;
        case (k)
            4'd0, 4'd8: w = 14'd3165;
            4'd1, 4'd7: w = 14'd5500;
            4'd2, 4'd6: w = 14'd8162;
            4'd3, 4'd5: w = 14'd10343;
            4'd4: w = 14'd11193;
            default: w = 14'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== sv/gaussian_smoothed_slope_filter_top.sv =====
// Gaussian-smoothed slope filter: bit-serial slope, smoothing and clamping of a sample series.
//
// Input items (time, value, end flag) enter on the in channel; an item is taken when
// i_in_valid is high and o_in_stall is low. Result items leave on the out channel and are
// taken when o_out_valid is high and i_out_stall is low. Registers are written through the
// cfg channel (index 0 minimum step, 1 lower clamp, 2 upper clamp); the user must write
// them only while the block is idle, which the block itself does not enforce. Each slope
// passes a shift-add multiplier (one bit of the scale a cycle) and a restoring divider
// (one quotient bit a cycle). Each result runs a multiply-accumulate over up to nine taps,
// one weight bit a cycle, then the same divider. A final item computes two slopes and up
// to six results. Results lag the input by five samples; the final item flushes the
// remainder. o_in_stall is high while an item is being worked on. The output register lets
// the next item enter while a result waits; a held result only blocks the loading of the
// next one. Reset restores the register defaults and starts a new, empty series.
module gaussian_smoothed_slope_filter_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gssf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gssf_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);
    import gssf_pkg::*;

    t_state r_state, n_state;
    logic [15:0] r_min;
    logic [23:0] r_clo;
    logic [22:0] r_chi;
    logic [31:0] r_th [0:5];
    logic [31:0] n_th [0:5];
    logic [23:0] r_vh [0:2];
    logic [23:0] n_vh [0:2];
    logic [31:0] r_rr [0:9];
    logic [31:0] n_rr [0:9];
    logic [3:0] r_seen, n_seen, r_m, n_m, r_qc, n_qc, r_k, n_k;
    logic r_last, n_last, r_pass, n_pass, r_smooth, n_smooth, r_neg, n_neg;
    logic [48:0] r_acc, n_acc, r_ma, n_ma, r_dq, n_dq;
    logic [23:0] r_mb, n_mb;
    logic [31:0] r_rem, n_rem, r_dd, n_dd;
    logic [5:0] r_cnt, n_cnt;
    logic [16:0] r_ws, n_ws;
    logic r_ov, n_ov;
    t_out_item r_od, n_od;

    logic in_acc, use_c, ge, incl;
    logic [31:0] t0, sat, sm, lo, hi, clamped;
    logic [23:0] v0;
    logic [32:0] dt, rem_sh, rem_sub;
    logic [24:0] dv;
    logic [4:0] q;
    logic [3:0] qmin, qmax, qfirst;
    logic [2:0] tidx;
    logic [13:0] w;

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_out_data = r_od;
    assign in_acc = i_in_valid && !o_in_stall;

    always_comb begin
        use_c = !r_pass && (r_m >= 4'd2);
        t0 = use_c ? r_th[3] : r_th[4];
        v0 = use_c ? r_vh[0] : r_vh[1];
        dt = {1'b0, r_th[5]} - {1'b0, t0};
        dv = {r_vh[2][23], r_vh[2]} - {v0[23], v0};
        rem_sh = {r_rem, r_dq[48]};
        rem_sub = rem_sh - {1'b0, r_dd};
        ge = (rem_sh >= {1'b0, r_dd});
        if (r_neg) begin
            sat = ((|r_dq[48:32]) || (r_dq[31] && (|r_dq[30:0])))
                ? 32'h80000000 : (~r_dq[31:0] + 32'd1);
            sm = ~r_dq[31:0] + 32'd1;
        end else begin
            sat = (|r_dq[48:31]) ? 32'h7FFFFFFF : r_dq[31:0];
            sm = r_dq[31:0];
        end
        lo = {{8{r_clo[23]}}, r_clo};
        hi = {9'd0, r_chi};
        clamped = ($signed(sm) < $signed(lo)) ? lo : sm;
        if ($signed(clamped) > $signed(hi)) begin
            clamped = hi;
        end
        qmin = 4'd9 - r_m;
        qmax = r_last ? 4'd9 : 4'd8;
        qfirst = (qmin > 4'd4) ? qmin : 4'd4;
        q = {1'b0, r_qc} + {1'b0, r_k} - 5'd4;
        incl = (q >= {1'b0, qmin}) && (q <= {1'b0, qmax});
        w = gauss_weight(r_k);
        tidx = 3'(r_qc - 4'd4);
    end

    always_comb begin
        n_state = r_state;
        n_th = r_th;
        n_vh = r_vh;
        n_rr = r_rr;
        n_seen = r_seen;
        n_m = r_m;
        n_qc = r_qc;
        n_k = r_k;
        n_last = r_last;
        n_pass = r_pass;
        n_smooth = r_smooth;
        n_neg = r_neg;
        n_acc = r_acc;
        n_ma = r_ma;
        n_mb = r_mb;
        n_dq = r_dq;
        n_rem = r_rem;
        n_dd = r_dd;
        n_cnt = r_cnt;
        n_ws = r_ws;
        n_ov = r_ov && i_out_stall;
        n_od = r_od;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    for (int i = 0; i < 5; i++) begin
                        n_th[i] = r_th[i + 1];
                    end
                    n_th[5] = i_in_data.sample_time_us;
                    n_vh[0] = r_vh[1];
                    n_vh[1] = r_vh[2];
                    n_vh[2] = i_in_data.sample_value;
                    n_rr[9] = 32'd0;
                    n_m = r_seen;
                    n_last = i_in_data.end_of_series;
                    n_pass = 1'b0;
                    if (i_in_data.end_of_series) begin
                        n_seen = 4'd0;
                    end else begin
                        n_seen = (r_seen == 4'd9) ? 4'd9 : r_seen + 4'd1;
                    end
                    n_state = (r_seen != 4'd0) ? S_SLOPE : S_EMIT_START;
                end
            end
            S_SLOPE: begin
                n_smooth = 1'b0;
                n_acc = 49'd0;
                if (dt[32] || (dt[31:0] <= {16'd0, r_min})) begin
                    n_dq = 49'd0;
                    n_neg = 1'b0;
                    n_state = S_SLOPE_END;
                end else begin
                    n_ma = {{24{dv[24]}}, dv};
                    n_mb = SLOPE_SCALE;
                    n_dd = dt[31:0];
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_mb[0]) begin
                    n_acc = r_acc + r_ma;
                end
                n_ma = {r_ma[47:0], 1'b0};
                n_mb = {1'b0, r_mb[23:1]};
                if (r_mb[23:1] == 23'd0) begin
                    if (r_smooth) begin
                        n_k = r_k + 4'd1;
                        n_state = S_TAP_LOAD;
                    end else begin
                        n_state = S_DIVSET;
                    end
                end
            end
            S_DIVSET: begin
                n_neg = r_acc[48];
                n_dq = r_acc[48] ? (~r_acc + 49'd1) : r_acc;
                n_rem = 32'd0;
                n_cnt = 6'd0;
                if (r_smooth) begin
                    n_dd = {15'd0, r_ws};
                end
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = ge ? rem_sub[31:0] : rem_sh[31:0];
                n_dq = {r_dq[47:0], ge};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd48) begin
                    n_state = r_smooth ? S_EMIT : S_SLOPE_END;
                end
            end
            S_SLOPE_END: begin
                if (!r_pass) begin
                    for (int i = 0; i < 8; i++) begin
                        n_rr[i] = r_rr[i + 1];
                    end
                    n_rr[8] = sat;
                    if (r_last) begin
                        n_pass = 1'b1;
                        n_state = S_SLOPE;
                    end else begin
                        n_state = S_EMIT_START;
                    end
                end else begin
                    n_rr[9] = sat;
                    n_state = S_EMIT_START;
                end
            end
            S_EMIT_START: begin
                n_acc = 49'd0;
                n_ws = 17'd0;
                n_k = 4'd0;
                n_smooth = 1'b1;
                if (!r_last && r_m >= 4'd5) begin
                    n_qc = 4'd4;
                    n_state = S_TAP_LOAD;
                end else if (r_last && r_m >= 4'd2) begin
                    n_qc = qfirst;
                    n_state = S_TAP_LOAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TAP_LOAD: begin
                if (r_k == 4'd9) begin
                    n_state = S_DIVSET;
                end else if (incl) begin
                    n_ma = {{17{r_rr[q[3:0]][31]}}, r_rr[q[3:0]]};
                    n_mb = {10'd0, w};
                    n_ws = r_ws + {3'd0, w};
                    n_state = S_MUL;
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
            S_EMIT: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov = 1'b1;
                    n_od.out_time_us = r_th[tidx];
                    n_od.smoothed_slope = clamped[23:0];
                    n_od.last_result = r_last && (r_qc == 4'd9);
                    if (r_last && r_qc != 4'd9) begin
                        n_qc = r_qc + 4'd1;
                        n_k = 4'd0;
                        n_acc = 49'd0;
                        n_ws = 17'd0;
                        n_state = S_TAP_LOAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seen <= 4'd0;
            r_ov <= 1'b0;
            r_min <= MIN_STEP_RESET;
            r_clo <= CLAMP_LOW_RESET;
            r_chi <= CLAMP_HIGH_RESET;
        end else begin
            r_state <= n_state;
            r_seen <= n_seen;
            r_ov <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIN_STEP: r_min <= i_cfg_data[15:0];
                    CFG_CLAMP_LOW: r_clo <= i_cfg_data;
                    CFG_CLAMP_HIGH: r_chi <= i_cfg_data[22:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_th <= n_th;
        r_vh <= n_vh;
        r_rr <= n_rr;
        r_m <= n_m;
        r_qc <= n_qc;
        r_k <= n_k;
        r_last <= n_last;
        r_pass <= n_pass;
        r_smooth <= n_smooth;
        r_neg <= n_neg;
        r_acc <= n_acc;
        r_ma <= n_ma;
        r_mb <= n_mb;
        r_dq <= n_dq;
        r_rem <= n_rem;
        r_dd <= n_dd;
        r_cnt <= n_cnt;
        r_ws <= n_ws;
        r_od <= n_od;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block took a second item without working on the first");
    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= 4'd9)
        else $error("sample count beyond kernel width");
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dd))
        else $error("divider remainder not below divisor");
    a_centre_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP_LOAD) |-> (r_qc >= 4'd4 && r_qc <= 4'd9))
        else $error("kernel centre out of range");
`endif

endmodule

// ===== tb/tb_gaussian_smoothed_slope_filter_top.sv =====
// Testbench of the Gaussian-smoothed slope filter, checked against a predictor of its own.
`timescale 1ns / 100ps

module tb_gaussian_smoothed_slope_filter_top;
    import gssf_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    gaussian_smoothed_slope_filter_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state.
    logic [15:0] p_min_step;
    logic signed [31:0] p_clamp_low, p_clamp_high;
    logic [31:0] hist_time [0:5];
    logic signed [31:0] hist_value [0:1];
    logic signed [31:0] hist_slope [0:8];
    int unsigned series_count;

    t_in_item pending_items[$];
    t_out_item expected_results[$];
    int unsigned errors = 0;
    int unsigned sent_count = 0;
    int sender_idle = 14;
    int receiver_idle = 49;
    bit hold_off = 1'b0;
    longint unsigned cycle_count = 0;

    function automatic logic signed [63:0] kernel_weight(input int k);
        case (k)
            0, 8: return 3165;
            1, 7: return 5500;
            2, 6: return 8162;
            3, 5: return 10343;
            default: return 11193;
        endcase
    endfunction

    function automatic logic signed [31:0] slope_of(input logic [31:0] t0,
            input logic signed [31:0] v0, input logic [31:0] t1, input logic signed [31:0] v1);
        logic signed [63:0] dt, q;
        dt = $signed({32'd0, t1}) - $signed({32'd0, t0});
        if (dt <= $signed({48'd0, p_min_step}))
            return 0;
        q = (64'(v1) - 64'(v0)) * 64'sd10000000 / dt;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic void push_smoothed(input logic signed [31:0] taps [0:9], input int qc,
            input int qmin, input int qmax, input bit last);
        logic signed [63:0] acc, wsum, sm;
        t_out_item r;
        int q;
        acc = 0;
        wsum = 0;
        for (int k = -4; k <= 4; k++) begin
            q = qc + k;
            if (q >= qmin && q <= qmax) begin
                acc += 64'(taps[q]) * kernel_weight(k + 4);
                wsum += kernel_weight(k + 4);
            end
        end
        sm = wsum > 0 ? acc / wsum : 0;
        if (sm < 64'(p_clamp_low))
            sm = 64'(p_clamp_low);
        if (sm > 64'(p_clamp_high))
            sm = 64'(p_clamp_high);
        r.out_time_us = hist_time[qc - 4];
        r.smoothed_slope = sm[23:0];
        r.last_result = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_slopes(input t_in_item it);
        logic signed [31:0] v, s;
        logic signed [31:0] taps [0:9];
        int m, qmin;
        v = 32'(it.sample_value);
        m = series_count > 9 ? 9 : series_count;
        for (int i = 0; i < 5; i++)
            hist_time[i] = hist_time[i + 1];
        hist_time[5] = it.sample_time_us;
        if (m >= 1) begin
            s = (m == 1) ? slope_of(hist_time[4], hist_value[1], it.sample_time_us, v)
                         : slope_of(hist_time[3], hist_value[0], it.sample_time_us, v);
            for (int i = 0; i < 8; i++)
                hist_slope[i] = hist_slope[i + 1];
            hist_slope[8] = s;
        end
        for (int i = 0; i < 9; i++)
            taps[i] = hist_slope[i];
        taps[9] = (it.end_of_series && m >= 1)
            ? slope_of(hist_time[4], hist_value[1], it.sample_time_us, v) : 0;
        hist_value[0] = hist_value[1];
        hist_value[1] = v;
        qmin = 9 - m;
        if (!it.end_of_series) begin
            if (m >= 5)
                push_smoothed(taps, 4, qmin, 8, 1'b0);
            series_count = m + 1 > 9 ? 9 : m + 1;
        end else begin
            if (m >= 2)
                for (int qc = 4; qc <= 9; qc++)
                    if (qc >= qmin)
                        push_smoothed(taps, qc, qmin, 9, qc == 9);
            series_count = 0;
        end
    endfunction

    // Driver.
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            predict_slopes(i_in_data);
            sent_count <= sent_count + 1;
        end
        if (!i_in_valid || !o_in_stall) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_items.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out_data);
                errors++;
            end else begin
                t_out_item e;
                e = expected_results.pop_front();
                if (e.out_time_us !== o_out_data.out_time_us)
                    $display("%0t: time expected %h actual %h", $time, e.out_time_us,
                             o_out_data.out_time_us);
                if (e.smoothed_slope !== o_out_data.smoothed_slope)
                    $display("%0t: slope expected %h actual %h", $time, e.smoothed_slope,
                             o_out_data.smoothed_slope);
                if (e.last_result !== o_out_data.last_result)
                    $display("%0t: last expected %b actual %b", $time, e.last_result,
                             o_out_data.last_result);
                if (e !== o_out_data)
                    errors++;
            end
        end
        i_out_stall <= hold_off || ($urandom_range(99) < receiver_idle);
        if (cycle_count > 64'd12000000) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_register(input logic [1:0] index, input logic [23:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_MIN_STEP: p_min_step = value[15:0];
            CFG_CLAMP_LOW: p_clamp_low = 32'($signed(value));
            default: p_clamp_high = {9'd0, value[22:0]};
        endcase
    endtask

    task automatic drain_all();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (1500) @(posedge i_clk);
    endtask

    task automatic add_series(input int len, input int mode);
        t_in_item it;
        logic [31:0] t;
        t = $urandom_range(3) == 0 ? $urandom : $urandom_range(100000);
        for (int i = 0; i < len; i++) begin
            it.sample_time_us = t;
            case (mode)
                0: it.sample_value = 24'($urandom);
                1: it.sample_value = $signed(24'($urandom_range(2000))) + 24'sd100000;
                default: it.sample_value = (i % 2) ? 24'h7FFFFF : 24'h800000;
            endcase
            it.end_of_series = (i == len - 1);
            pending_items.push_back(it);
            case ($urandom_range(9))
                0: t = t - $urandom_range(5000);
                1: t = t;
                2: t = t + $urandom;
                3: t = t + p_min_step;
                default: t = t + $urandom_range(20000);
            endcase
        end
    endtask

    initial begin
        t_in_item it;
        p_min_step = MIN_STEP_RESET;
        p_clamp_low = 32'($signed(CLAMP_LOW_RESET));
        p_clamp_high = {9'd0, CLAMP_HIGH_RESET};
        for (int i = 0; i < 6; i++) hist_time[i] = '0;
        for (int i = 0; i < 9; i++) hist_slope[i] = '0;
        hist_value[0] = 0;
        hist_value[1] = 0;
        series_count = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: short series, extremes, crossed clamps.
        add_series(1, 0);
        add_series(2, 0);
        add_series(3, 2);
        add_series(10, 2);
        it.sample_time_us = 32'hFFFFFFFF;
        it.sample_value = 24'h000000;
        it.end_of_series = 1'b0;
        pending_items.push_back(it);
        it.sample_time_us = 32'h0;
        it.end_of_series = 1'b1;
        pending_items.push_back(it);
        drain_all();
        write_register(CFG_MIN_STEP, 24'd0);
        write_register(CFG_CLAMP_LOW, 24'h800000);
        write_register(CFG_CLAMP_HIGH, 24'h7FFFFF);
        add_series(7, 2);
        drain_all();
        write_register(CFG_MIN_STEP, 24'hFFFF);
        write_register(CFG_CLAMP_LOW, 24'h000000);
        write_register(CFG_CLAMP_HIGH, 24'h000000);
        add_series(6, 0);
        drain_all();
        write_register(CFG_CLAMP_LOW, 24'h100000);
        write_register(CFG_CLAMP_HIGH, 24'h010000);
        write_register(CFG_MIN_STEP, 24'd10);
        add_series(5, 0);
        drain_all();

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle = phase == 0 ? 14 : (phase == 1 ? 49 : 0);
            receiver_idle = phase == 0 ? 49 : (phase == 1 ? 14 : 0);
            write_register(CFG_MIN_STEP, 24'($urandom_range(3000)));
            write_register(CFG_CLAMP_LOW, 24'h800000 | 24'($urandom_range(24'h7FFFFF)));
            write_register(CFG_CLAMP_HIGH, 24'($urandom_range(24'h7FFFFF)));
            if (phase == 0) begin
                hold_off = 1'b1;
                add_series(20, 1);
                repeat (6000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            while (pending_items.size() < 120) begin
                add_series($urandom_range(9) == 0 ? $urandom_range(1, 3)
                           : $urandom_range(4, 14), $urandom_range(9) < 6 ? 1 : 0);
            end
            drain_all();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
